FILE: sv/dfwd_pkg.sv
// Shared types and constants for the deauth flood window detector.
// Used by dfwd_ram users, the top level and the port checker.
package dfwd_pkg;

    localparam int unsigned TableSlotsDefault = 16;

    localparam logic [7:0]  FcDeauth   = 8'hC0;
    localparam logic [7:0]  FcDisassoc = 8'hA0;
    localparam logic [11:0] MinLen     = 12'd24;
    localparam logic [11:0] ReasonLen  = 12'd26;
    localparam logic [47:0] AddrOnes   = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] CountMax   = 16'hFFFF;

    localparam logic        KindBcast  = 1'b0;
    localparam logic        KindAlert  = 1'b1;

    localparam logic [1:0]  RegEnable  = 2'd0;
    localparam logic [1:0]  RegThresh  = 2'd1;
    localparam logic [1:0]  RegWindow  = 2'd2;

    localparam logic        EnableRst  = 1'b0;
    localparam logic [9:0]  ThreshRst  = 10'd10;
    localparam logic [23:0] WindowRst  = 24'd1000000;

    localparam int unsigned InDataW  = 232;
    localparam int unsigned OutDataW = 296;

    typedef struct packed {
        logic [47:0] bssid;
        logic [47:0] last_seen;
        logic [15:0] count;
        logic        alerted;
        logic [15:0] reason;
        logic        uniform;
    } t_ent;

    localparam int unsigned EntW = $bits(t_ent);

    typedef struct packed {
        logic        kind;
        logic [47:0] time_us;
        logic [47:0] bssid;
        logic [47:0] source;
        logic [47:0] dest;
        logic [15:0] reason;
        logic        uniform;
        logic [15:0] count;
        logic [3:0]  channel;
        logic [31:0] deauth_total;
        logic [31:0] disassoc_total;
        logic        last;
    } t_res;

endpackage

FILE: sv/dfwd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module dfwd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/deauth_flood_window_detector.sv
// Top level of the deauth/disassoc flood detector: APB registers, slot
// scan sequencer and result queue. Depends on dfwd_pkg and dfwd_ram.
//
// Usage:
// Frame headers enter on the s_axis channel (one transaction per frame),
// events leave on m_axis. A frame that is not an enabled management deauth
// or disassoc of at least 24 bytes is taken in idle and yields nothing.
// A counted frame walks the slot RAM one entry per cycle (registered read),
// then takes the chosen slot through select, age and write-back; its events
// are offered, and the next frame can be taken, once write-back is done.
// It yields zero, one or two events,
// a broadcast event ahead of a flood alert; tlast marks the frame's final
// event. s_axis tready is high only while no frame is in work.
// The queue holds up to two events; if the receiver still holds earlier
// events when a frame is ready to write back, the frame waits at that step.
// Reset clears the slot valid flags, both totals and the registers to their
// defaults; slot RAM contents are never cleared, an invalid slot's contents
// are never used. Registers: 0 enable, 1 alert_threshold, 2 window_length_us.
module deauth_flood_window_detector #(
    parameter int unsigned TABLE_SLOTS = dfwd_pkg::TableSlotsDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // fc[7:0], frame_length[19:8], reason_field[35:20], dest_addr[83:36],
    // source_addr[131:84], bssid[179:132], radio_channel[183:180], time_us[231:184]
    input  logic [dfwd_pkg::InDataW-1:0]  i_s_tdata,
    // is_management[0]
    input  logic         i_s_tuser,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // event_time_us[47:0], event_bssid[95:48], event_source[143:96],
    // event_dest[191:144], event_reason[207:192], reason_is_uniform[208],
    // window_count[224:209], event_channel[228:225], deauth_total[260:229],
    // disassoc_total[292:261], zero pad[295:293]
    output logic [dfwd_pkg::OutDataW-1:0] o_m_tdata,
    // event_kind[0]
    output logic         o_m_tuser,
    output logic         o_m_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int unsigned AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [AW:0] SlotsN = (AW+1)'(TABLE_SLOTS);

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StScan = 3'd1;
    localparam logic [2:0] StSel  = 3'd2;
    localparam logic [2:0] StAge  = 3'd3;
    localparam logic [2:0] StWb   = 3'd4;

    // configuration
    logic        r_enable;
    logic [9:0]  r_thresh;
    logic [23:0] r_window;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= dfwd_pkg::EnableRst;
            r_thresh <= dfwd_pkg::ThreshRst;
            r_window <= dfwd_pkg::WindowRst;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                dfwd_pkg::RegEnable: r_enable <= pwdata[0];
                dfwd_pkg::RegThresh: r_thresh <= pwdata[9:0];
                dfwd_pkg::RegWindow: r_window <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            dfwd_pkg::RegEnable: prdata = {31'd0, r_enable};
            dfwd_pkg::RegThresh: prdata = {22'd0, r_thresh};
            dfwd_pkg::RegWindow: prdata = {8'd0, r_window};
            default:             prdata = 32'd0;
        endcase
    end

    // input fields
    logic [7:0]  in_fc;
    logic [11:0] in_len;
    logic [15:0] in_rf;
    logic [47:0] in_da, in_sa, in_id, in_now;
    logic [3:0]  in_ch;
    assign in_fc  = i_s_tdata[7:0];
    assign in_len = i_s_tdata[19:8];
    assign in_rf  = i_s_tdata[35:20];
    assign in_da  = i_s_tdata[83:36];
    assign in_sa  = i_s_tdata[131:84];
    assign in_id  = i_s_tdata[179:132];
    assign in_ch  = i_s_tdata[183:180];
    assign in_now = i_s_tdata[231:184];

    logic [2:0]  r_state;
    logic        s_acc, is_de, is_dis, qualify;
    assign o_s_tready = (r_state == StIdle);
    assign s_acc   = i_s_tvalid && o_s_tready;
    assign is_de   = (in_fc == dfwd_pkg::FcDeauth);
    assign is_dis  = (in_fc == dfwd_pkg::FcDisassoc);
    assign qualify = r_enable && i_s_tuser && (in_len >= dfwd_pkg::MinLen) && (is_de || is_dis);

    // frame latches
    logic [47:0] r_da, r_sa, r_id, r_now;
    logic [15:0] r_reason;
    logic [3:0]  r_ch;
    logic        r_bc;
    logic [31:0] r_deauth, r_disassoc;

    // scan state
    logic [AW:0]   r_ridx;
    logic          r_cv;
    logic [AW-1:0] r_ci;
    logic          r_hit, r_fvld, r_ovld;
    logic [AW-1:0] r_hidx, r_fidx, r_oidx, r_sel;
    logic [47:0]   r_olast;
    dfwd_pkg::t_ent r_ent;
    logic          r_stale;
    logic [TABLE_SLOTS-1:0] r_valid;

    // slot RAM
    logic                     ram_we;
    logic [AW-1:0]            ram_raddr;
    logic [dfwd_pkg::EntW-1:0] ram_rdata;
    dfwd_pkg::t_ent           rd_ent, wb_ent;
    assign ram_raddr = r_ridx[AW-1:0];
    assign rd_ent    = dfwd_pkg::t_ent'(ram_rdata);

    dfwd_ram #(
        .WIDTH(dfwd_pkg::EntW),
        .DEPTH(TABLE_SLOTS)
    ) u_slots (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_sel),
        .i_wdata(wb_ent),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // result queue
    dfwd_pkg::t_res r_q0, r_q1;
    logic [1:0]     r_qn;
    logic           m_acc;
    assign o_m_tvalid = (r_qn != 2'd0);
    assign m_acc      = o_m_tvalid && i_m_tready;
    assign o_m_tuser  = r_q0.kind;
    assign o_m_tlast  = r_q0.last;
    assign o_m_tdata  = {3'd0, r_q0.disassoc_total, r_q0.deauth_total, r_q0.channel,
                         r_q0.count, r_q0.uniform, r_q0.reason, r_q0.dest,
                         r_q0.source, r_q0.bssid, r_q0.time_us};

    // write-back math
    logic [15:0] cnt0, cnt1;
    logic        alerted0, uni1, alert;
    logic [15:0] reason1;
    dfwd_pkg::t_res bc_res, al_res;

    always_comb begin
        cnt0     = r_stale ? 16'd0 : r_ent.count;
        alerted0 = r_stale ? 1'b0 : r_ent.alerted;
        if (cnt0 == 16'd0) begin
            reason1 = r_reason;
            uni1    = 1'b1;
        end else begin
            reason1 = r_ent.reason;
            uni1    = r_ent.uniform && (r_reason == r_ent.reason);
        end
        cnt1  = (cnt0 == dfwd_pkg::CountMax) ? cnt0 : cnt0 + 16'd1;
        alert = !alerted0 && (cnt1 >= {6'd0, r_thresh});

        wb_ent.bssid     = r_ent.bssid;
        wb_ent.last_seen = r_now;
        wb_ent.count     = cnt1;
        wb_ent.alerted   = alerted0 || alert;
        wb_ent.reason    = reason1;
        wb_ent.uniform   = uni1;

        bc_res.kind           = dfwd_pkg::KindBcast;
        bc_res.time_us        = r_now;
        bc_res.bssid          = r_id;
        bc_res.source         = r_sa;
        bc_res.dest           = r_da;
        bc_res.reason         = r_reason;
        bc_res.uniform        = 1'b0;
        bc_res.count          = 16'd0;
        bc_res.channel        = r_ch;
        bc_res.deauth_total   = r_deauth;
        bc_res.disassoc_total = r_disassoc;
        bc_res.last           = !alert;

        al_res.kind           = dfwd_pkg::KindAlert;
        al_res.time_us        = r_now;
        al_res.bssid          = r_ent.bssid;
        al_res.source         = 48'd0;
        al_res.dest           = 48'd0;
        al_res.reason         = reason1;
        al_res.uniform        = uni1;
        al_res.count          = cnt1;
        al_res.channel        = r_ch;
        al_res.deauth_total   = r_deauth;
        al_res.disassoc_total = r_disassoc;
        al_res.last           = 1'b1;
    end

    assign ram_we = (r_state == StWb) && (r_qn == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= StIdle;
            r_valid    <= '0;
            r_deauth   <= 32'd0;
            r_disassoc <= 32'd0;
            r_qn       <= 2'd0;
            r_cv       <= 1'b0;
        end else begin
            unique case (r_state)
                StIdle: begin
                    if (s_acc && qualify) begin
                        if (is_de) begin
                            r_deauth <= r_deauth + 32'd1;
                        end else begin
                            r_disassoc <= r_disassoc + 32'd1;
                        end
                        r_da     <= in_da;
                        r_sa     <= in_sa;
                        r_id     <= in_id;
                        r_now    <= in_now;
                        r_ch     <= in_ch;
                        r_reason <= (in_len >= dfwd_pkg::ReasonLen) ? in_rf : 16'd0;
                        r_bc     <= is_de && (in_da == dfwd_pkg::AddrOnes || in_da == 48'd0);
                        r_ridx   <= '0;
                        r_cv     <= 1'b0;
                        r_hit    <= 1'b0;
                        r_fvld   <= 1'b0;
                        r_ovld   <= 1'b0;
                        r_state  <= StScan;
                    end
                end
                StScan: begin
                    // issue one read per cycle, compare the previous one
                    if (r_ridx < SlotsN) begin
                        r_cv   <= 1'b1;
                        r_ci   <= r_ridx[AW-1:0];
                        r_ridx <= r_ridx + 1'b1;
                    end else begin
                        r_cv <= 1'b0;
                    end
                    if (r_cv) begin
                        if (r_valid[r_ci]) begin
                            if (!r_hit && rd_ent.bssid == r_id) begin
                                r_hit  <= 1'b1;
                                r_hidx <= r_ci;
                                r_ent  <= rd_ent;
                            end
                            if (!r_ovld || rd_ent.last_seen < r_olast) begin
                                r_ovld  <= 1'b1;
                                r_oidx  <= r_ci;
                                r_olast <= rd_ent.last_seen;
                            end
                        end else if (!r_fvld) begin
                            r_fvld <= 1'b1;
                            r_fidx <= r_ci;
                        end
                    end
                    if (r_ridx == SlotsN && !r_cv) begin
                        r_state <= StSel;
                    end
                end
                StSel: begin
                    if (r_hit) begin
                        r_sel <= r_hidx;
                    end else begin
                        r_sel <= r_fvld ? r_fidx : r_oidx;
                        r_ent <= '{bssid: r_id, last_seen: r_now, count: 16'd0,
                                   alerted: 1'b0, reason: 16'd0, uniform: 1'b0};
                    end
                    r_state <= StAge;
                end
                StAge: begin
                    r_stale <= (r_now - r_ent.last_seen) > {24'd0, r_window};
                    r_state <= StWb;
                end
                StWb: begin
                    // hold until earlier events are drained
                    if (r_qn == 2'd0) begin
                        r_valid[r_sel] <= 1'b1;
                        r_q0 <= r_bc ? bc_res : al_res;
                        r_q1 <= al_res;
                        r_qn <= {1'b0, r_bc} + {1'b0, alert};
                        r_state <= StIdle;
                    end
                end
                default: r_state <= StIdle;
            endcase

            if (m_acc) begin
                r_q0 <= r_q1;
                r_qn <= r_qn - 2'd1;
            end
        end
    end
endmodule

FILE: sv/dfwd_chk.sv
// Port-level checker for the deauth flood window detector, bound to the top.
// Depends on dfwd_pkg for the event kind codes.
module dfwd_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic [dfwd_pkg::OutDataW-1:0]   o_m_tdata,
    input logic                            o_m_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready
);
    // a stalled event stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("event dropped while stalled");

    a_bcast_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == dfwd_pkg::KindBcast |->
        (o_m_tdata[191:144] == dfwd_pkg::AddrOnes || o_m_tdata[191:144] == 48'd0))
        else $error("broadcast event with unicast destination");

    a_bcast_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == dfwd_pkg::KindBcast |->
        o_m_tdata[224:208] == 17'd0)
        else $error("broadcast event carries window fields");

    a_alert_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == dfwd_pkg::KindAlert |->
        o_m_tdata[191:96] == 96'd0)
        else $error("alert carries addresses");

    a_alert_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == dfwd_pkg::KindAlert |->
        o_m_tdata[224:209] != 16'd0)
        else $error("alert with empty window");
endmodule

bind deauth_flood_window_detector dfwd_chk u_dfwd_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_m_tdata (o_m_tdata),
    .o_m_tuser (o_m_tuser),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready)
);
